### rtl/rotary_encoder_interface_unit_macros.svh
// Assertion macros used by the checker
`ifndef ROTARY_ENCODER_INTERFACE_UNIT_MACROS_SVH
`define ROTARY_ENCODER_INTERFACE_UNIT_MACROS_SVH

// Antecedent holds at this edge -> consequent holds at this edge
`define REI_ASSERT_IMPL(label, clock, rstn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds at this edge -> consequent holds at the next edge
`define REI_ASSERT_NEXT(label, clock, rstn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Expression must never be true
`define REI_ASSERT_NEVER(label, clock, rstn, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) !(expr)) \
        else $error(msg);

`endif

### rtl/rei_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rei_pkg;

    localparam int POS_W   = 16;
    localparam int TIME_W  = 32;
    localparam int DEB_W   = 16;
    localparam int ACT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    localparam logic signed [POS_W-1:0] POS_MAX_LIMIT = 16'sh7FFF;
    localparam logic signed [POS_W-1:0] POS_MIN_LIMIT = 16'sh8000;

    localparam logic signed [POS_W-1:0] MAX_POS_RESET = 16'sd10;
    localparam logic signed [POS_W-1:0] MIN_POS_RESET = 16'sd1;
    localparam logic [DEB_W-1:0]        ROT_DEB_RESET = 16'd15;
    localparam logic [DEB_W-1:0]        BTN_DEB_RESET = 16'd50;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLK_CHANGE = 3'd0,
        ACT_BTN_FALL   = 3'd1,
        ACT_READ_POS   = 3'd2,
        ACT_READ_BTN   = 3'd3,
        ACT_WRITE_POS  = 3'd4,
        ACT_MOVED      = 3'd5
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_POS = 2'd0,
        REG_MIN_POS = 2'd1,
        REG_ROT_DEB = 2'd2,
        REG_BTN_DEB = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] max_position;
        logic signed [POS_W-1:0] min_position;
        logic [DEB_W-1:0]        rotation_debounce_ms;
        logic [DEB_W-1:0]        button_debounce_ms;
    } cfg_t;

    typedef struct packed {
        action_t                 action;
        logic [TIME_W-1:0]       time_ms;
        logic                    clk_level;
        logic                    dt_level;
        logic signed [POS_W-1:0] new_position;
    } item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    pressed;
        logic                    moved_flag;
    } result_t;

endpackage

`default_nettype wire

### rtl/rei_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rei_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [rei_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rei_pkg::CFG_DAT_W-1:0]    cfg_data,
    output rei_pkg::cfg_t                         cfg
);
    import rei_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_POS: cfg_next.max_position         = $signed(cfg_data);
                REG_MIN_POS: cfg_next.min_position         = $signed(cfg_data);
                REG_ROT_DEB: cfg_next.rotation_debounce_ms = cfg_data;
                REG_BTN_DEB: cfg_next.button_debounce_ms   = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_position         <= MAX_POS_RESET;
            cfg_reg.min_position         <= MIN_POS_RESET;
            cfg_reg.rotation_debounce_ms <= ROT_DEB_RESET;
            cfg_reg.button_debounce_ms   <= BTN_DEB_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/rei_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rei_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire rei_pkg::item_t item,
    input  wire rei_pkg::cfg_t  cfg,
    output rei_pkg::result_t   result
);
    import rei_pkg::*;

    logic                    last_clk_reg, last_clk_next;
    logic signed [POS_W-1:0] position_reg, position_next;
    logic                    button_flag_reg, button_flag_next;
    logic [TIME_W-1:0]       rot_time_reg, rot_time_next;
    logic [TIME_W-1:0]       btn_time_reg, btn_time_next;
    logic signed [POS_W-1:0] reported_reg, reported_next;

    logic [TIME_W-1:0] rot_elapsed;
    logic [TIME_W-1:0] btn_elapsed;
    logic              rot_open;
    logic              btn_open;

    // elapsed times wrap modulo 2^32
    assign rot_elapsed = item.time_ms - rot_time_reg;
    assign btn_elapsed = item.time_ms - btn_time_reg;
    assign rot_open    = rot_elapsed > {{(TIME_W-DEB_W){1'b0}}, cfg.rotation_debounce_ms};
    assign btn_open    = btn_elapsed > {{(TIME_W-DEB_W){1'b0}}, cfg.button_debounce_ms};

    always_comb
    begin
        last_clk_next    = last_clk_reg;
        position_next    = position_reg;
        button_flag_next = button_flag_reg;
        rot_time_next    = rot_time_reg;
        btn_time_next    = btn_time_reg;
        reported_next    = reported_reg;
        result.pressed    = 1'b0;
        result.moved_flag = 1'b0;

        unique case (item.action)
            ACT_CLK_CHANGE:
            begin
                if (rot_open && (item.clk_level != last_clk_reg))
                begin
                    if (item.dt_level != item.clk_level)
                    begin
                        if (position_reg != POS_MAX_LIMIT)
                            position_next = position_reg + 16'sd1;
                    end
                    else
                    begin
                        if (position_reg != POS_MIN_LIMIT)
                            position_next = position_reg - 16'sd1;
                    end
                    last_clk_next = item.clk_level;
                end
                rot_time_next = item.time_ms;
            end
            ACT_BTN_FALL:
            begin
                if (btn_open)
                    button_flag_next = 1'b1;
                btn_time_next = item.time_ms;
            end
            ACT_READ_POS:
            begin
                // max test wins when the limits cross
                if (position_reg > cfg.max_position)
                    position_next = cfg.max_position;
                else if (position_reg < cfg.min_position)
                    position_next = cfg.min_position;
            end
            ACT_READ_BTN:
            begin
                result.pressed   = button_flag_reg;
                button_flag_next = 1'b0;
            end
            ACT_WRITE_POS:
            begin
                position_next = item.new_position;
            end
            ACT_MOVED:
            begin
                if (reported_reg != position_reg)
                begin
                    reported_next     = position_reg;
                    result.moved_flag = 1'b1;
                end
            end
            default:
            begin
                position_next = position_reg;
            end
        endcase

        result.position = position_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_clk_reg    <= 1'b0;
            position_reg    <= '0;
            button_flag_reg <= 1'b0;
            rot_time_reg    <= '0;
            btn_time_reg    <= '0;
            reported_reg    <= '0;
        end
        else if (fire)
        begin
            last_clk_reg    <= last_clk_next;
            position_reg    <= position_next;
            button_flag_reg <= button_flag_next;
            rot_time_reg    <= rot_time_next;
            btn_time_reg    <= btn_time_next;
            reported_reg    <= reported_next;
        end
    end

endmodule

`default_nettype wire

### rtl/rotary_encoder_interface_unit.sv
// Rotary encoder front end with debounce.
// Input stream (s_*): one word per action. s_tuser carries the action code,
// s_tdata the timestamp, pin levels and the value for a position write.
// Output stream (m_*): exactly one word per accepted input word, in order,
// carrying the position after the action plus the pressed and moved flags.
// Configuration: cfg_we/cfg_index/cfg_data write the clamp limits and the
// two debounce windows; write them only while no word is in flight.
// Path: an accepted word sits in the input register; its result is loaded into
// the result register once the output is free, and then shows on m_tvalid.
// Throughput: one word per cycle while m_tready stays high; the state update
// and the result are formed in one pass between the input and result registers.
// Reset: all encoder state clears, config registers take their default values,
// both streams come up empty; the input and result data registers are not reset.
// Stall: a result held by a low m_tready stays stable; one more word waits
// in the input register, then s_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module rotary_encoder_interface_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [31:0] time_ms, [32] clk_level, [33] dt_level, [49:34] new_position
    input  wire logic [rei_pkg::IN_DATA_W-1:0]     s_tdata,
    // [2:0] action
    input  wire logic [rei_pkg::ACT_W-1:0]         s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [15:0] position, [16] pressed, [17] moved_flag
    output logic [rei_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [rei_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rei_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import rei_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t result_reg;
    result_t result;
    cfg_t    cfg;
    logic    advance;
    logic    s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.action       <= action_t'(s_tuser);
            item_reg.time_ms      <= s_tdata[31:0];
            item_reg.clk_level    <= s_tdata[32];
            item_reg.dt_level     <= s_tdata[33];
            item_reg.new_position <= $signed(s_tdata[49:34]);
        end
        if (advance)
            result_reg <= result;
    end

    rei_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rei_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, result_reg.moved_flag, result_reg.pressed,
                       result_reg.position};

endmodule

`default_nettype wire

### rtl/rei_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rotary_encoder_interface_unit_macros.svh"

module rei_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [rei_pkg::OUT_DATA_W-1:0] m_tdata
);
    import rei_pkg::*;

    `REI_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `REI_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready, "input stalled with empty output")
    `REI_ASSERT_NEVER(a_one_flag, clk, rst_n, m_tvalid && m_tdata[16] && m_tdata[17], "pressed and moved in one word")
    `REI_ASSERT_IMPL(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[23:18] == 6'd0, "nonzero pad bits in result")

endmodule

bind rotary_encoder_interface_unit rei_checker u_rei_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
